@@ rtl/itr_pkg.sv @@
// Shared types, constants and the digit-to-symbols function of the Roman numeral converter.
package itr_pkg;

  // Field widths.
  localparam int unsigned NumberWidth = 14;
  localparam int unsigned SymbolWidth = 8;
  localparam int unsigned ThouWidth   = 5;   // floor(16383 / 1000) = 16
  localparam int unsigned RemWidth    = 10;  // remainder below 1000
  localparam int unsigned TensWidth   = 7;   // remainder / 10, below 100
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned MaxChars    = 16;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned LineWidth   = MaxChars * SymbolWidth;
  localparam int unsigned GroupWidth  = 4 * SymbolWidth;

  // Reciprocal constants for division by 1000 and by 10. The shifts are chosen so
  // that the truncated product is exact over the whole input range.
  localparam int unsigned Recip1000 = 8389;
  localparam int unsigned Shift1000 = 23;
  localparam int unsigned Recip10   = 205;
  localparam int unsigned Shift10   = 11;
  localparam int unsigned Thousand  = 1000;
  localparam int unsigned Ten       = 10;

  // ASCII codes of the numeral symbols.
  localparam logic [SymbolWidth-1:0] CharM = 8'h4D;
  localparam logic [SymbolWidth-1:0] CharD = 8'h44;
  localparam logic [SymbolWidth-1:0] CharC = 8'h43;
  localparam logic [SymbolWidth-1:0] CharL = 8'h4C;
  localparam logic [SymbolWidth-1:0] CharX = 8'h58;
  localparam logic [SymbolWidth-1:0] CharV = 8'h56;
  localparam logic [SymbolWidth-1:0] CharI = 8'h49;

  // Decimal digits of one number, handed from the splitter to the emitter.
  typedef struct packed {
    logic [ThouWidth-1:0]  thou;
    logic [DigitWidth-1:0] hun;
    logic [DigitWidth-1:0] tens;
    logic [DigitWidth-1:0] ones;
  } digits_t;

  // Up to four symbols, first symbol in the low byte, unused bytes zero.
  typedef struct packed {
    logic [GroupWidth-1:0] chars;
    logic [2:0]            len;
  } group_t;

  // Symbols for one decimal digit with the given one, five and ten symbols.
  function automatic group_t digit_group(input logic [DigitWidth-1:0] digit,
                                         input logic [SymbolWidth-1:0] one,
                                         input logic [SymbolWidth-1:0] five,
                                         input logic [SymbolWidth-1:0] ten);
    group_t g;
    g.chars = '0;
    g.len   = 3'd0;
    case (digit)
      4'd1: begin g.chars = {24'h0, one};             g.len = 3'd1; end
      4'd2: begin g.chars = {16'h0, one, one};        g.len = 3'd2; end
      4'd3: begin g.chars = {8'h0, one, one, one};    g.len = 3'd3; end
      4'd4: begin g.chars = {16'h0, five, one};       g.len = 3'd2; end
      4'd5: begin g.chars = {24'h0, five};            g.len = 3'd1; end
      4'd6: begin g.chars = {16'h0, one, five};       g.len = 3'd2; end
      4'd7: begin g.chars = {8'h0, one, one, five};   g.len = 3'd3; end
      4'd8: begin g.chars = {one, one, one, five};    g.len = 3'd4; end
      4'd9: begin g.chars = {16'h0, ten, one};        g.len = 3'd2; end
      default: begin g.chars = '0;                    g.len = 3'd0; end
    endcase
    return g;
  endfunction

endpackage

@@ rtl/itr_split.sv @@
// Input register and three-stage pipeline that splits a number into decimal digits.
module itr_split (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    advance,
  input  logic                                    in_valid,
  input  logic [itr_pkg::NumberWidth-1:0]         number,
  output logic                                    out_valid,
  output itr_pkg::digits_t                        digits
);

  localparam int unsigned P1Width = itr_pkg::NumberWidth + 14;
  localparam int unsigned P2Width = itr_pkg::RemWidth + 8;
  localparam int unsigned P3Width = itr_pkg::TensWidth + 8;

  // Stage registers.
  logic                                s0_valid;
  logic [itr_pkg::NumberWidth-1:0]     s0_number;
  logic                                s1_valid;
  logic [itr_pkg::ThouWidth-1:0]       s1_thou;
  logic [itr_pkg::RemWidth-1:0]        s1_rem;
  logic                                s2_valid;
  logic [itr_pkg::ThouWidth-1:0]       s2_thou;
  logic [itr_pkg::TensWidth-1:0]       s2_t;
  logic [itr_pkg::DigitWidth-1:0]      s2_ones;
  logic                                s3_valid;
  itr_pkg::digits_t                    s3_digits;

  // Stage logic.
  logic [P1Width-1:0]                  prod1;
  logic [itr_pkg::ThouWidth-1:0]       thou_next;
  logic [itr_pkg::NumberWidth-1:0]     rem_full;
  logic [P2Width-1:0]                  prod2;
  logic [itr_pkg::TensWidth-1:0]       t_next;
  logic [itr_pkg::RemWidth-1:0]        ones_full;
  logic [P3Width-1:0]                  prod3;
  logic [itr_pkg::DigitWidth-1:0]      hun_next;
  logic [itr_pkg::TensWidth-1:0]       tens_full;

  always_comb begin
    // Thousands digit and the remainder below 1000.
    prod1     = P1Width'(s0_number) * P1Width'(itr_pkg::Recip1000);
    thou_next = prod1[itr_pkg::Shift1000 +: itr_pkg::ThouWidth];
    rem_full  = s0_number - itr_pkg::NumberWidth'(thou_next)
                * itr_pkg::NumberWidth'(itr_pkg::Thousand);
    // Remainder over ten and the ones digit.
    prod2     = P2Width'(s1_rem) * P2Width'(itr_pkg::Recip10);
    t_next    = prod2[itr_pkg::Shift10 +: itr_pkg::TensWidth];
    ones_full = s1_rem - itr_pkg::RemWidth'(t_next) * itr_pkg::RemWidth'(itr_pkg::Ten);
    // Hundreds and tens digits.
    prod3     = P3Width'(s2_t) * P3Width'(itr_pkg::Recip10);
    hun_next  = prod3[itr_pkg::Shift10 +: itr_pkg::DigitWidth];
    tens_full = s2_t - itr_pkg::TensWidth'(hun_next) * itr_pkg::TensWidth'(itr_pkg::Ten);
  end

  // The stages move together whenever advance is high: the last stage is empty or the emitter can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_number      <= number;
      s1_thou        <= thou_next;
      s1_rem         <= rem_full[itr_pkg::RemWidth-1:0];
      s2_thou        <= s1_thou;
      s2_t           <= t_next;
      s2_ones        <= ones_full[itr_pkg::DigitWidth-1:0];
      s3_digits.thou <= s2_thou;
      s3_digits.hun  <= hun_next;
      s3_digits.tens <= tens_full[itr_pkg::DigitWidth-1:0];
      s3_digits.ones <= s2_ones;
    end
  end

  assign out_valid = s3_valid;
  assign digits    = s3_digits;

endmodule

@@ rtl/itr_emit.sv @@
// Builds the numeral from the digits and shifts it out one character per cycle.
module itr_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  itr_pkg::digits_t                digits,
  output logic                            take,
  output logic                            strobe,
  output logic [itr_pkg::SymbolWidth-1:0] symbol,
  output logic                            is_empty,
  output logic                            is_last
);

  localparam int unsigned ShiftWidth = itr_pkg::CountWidth + 3;

  logic                              active;
  logic [itr_pkg::LineWidth-1:0]     chars;
  logic [itr_pkg::CountWidth-1:0]    count;
  logic                              empty;

  itr_pkg::group_t                   gm;
  itr_pkg::group_t                   gh;
  itr_pkg::group_t                   gt;
  itr_pkg::group_t                   go;
  logic [itr_pkg::CountWidth-1:0]    off_t;
  logic [itr_pkg::CountWidth-1:0]    off_o;
  logic [itr_pkg::CountWidth-1:0]    total;
  logic [itr_pkg::LineWidth-1:0]     line_next;

  always_comb begin
    gm.chars = '0;
    gm.len   = 3'd0;
    case (digits.thou)
      5'd1: begin
        gm.chars = {24'h0, itr_pkg::CharM};
        gm.len   = 3'd1;
      end
      5'd2: begin
        gm.chars = {16'h0, itr_pkg::CharM, itr_pkg::CharM};
        gm.len   = 3'd2;
      end
      5'd3: begin
        gm.chars = {8'h0, itr_pkg::CharM, itr_pkg::CharM, itr_pkg::CharM};
        gm.len   = 3'd3;
      end
      5'd4: begin
        gm.chars = {itr_pkg::CharM, itr_pkg::CharM, itr_pkg::CharM, itr_pkg::CharM};
        gm.len   = 3'd4;
      end
      default: begin
        // Zero thousands, and thousands above four, give no M.
        gm.chars = '0;
        gm.len   = 3'd0;
      end
    endcase

    gh = itr_pkg::digit_group(digits.hun, itr_pkg::CharC, itr_pkg::CharD, itr_pkg::CharM);
    gt = itr_pkg::digit_group(digits.tens, itr_pkg::CharX, itr_pkg::CharL, itr_pkg::CharC);
    go = itr_pkg::digit_group(digits.ones, itr_pkg::CharI, itr_pkg::CharV, itr_pkg::CharX);

    off_t = itr_pkg::CountWidth'(gm.len) + itr_pkg::CountWidth'(gh.len);
    off_o = off_t + itr_pkg::CountWidth'(gt.len);
    total = off_o + itr_pkg::CountWidth'(go.len);

    line_next = itr_pkg::LineWidth'(gm.chars)
              | (itr_pkg::LineWidth'(gh.chars) << ShiftWidth'({gm.len, 3'b000}))
              | (itr_pkg::LineWidth'(gt.chars) << ShiftWidth'({off_t, 3'b000}))
              | (itr_pkg::LineWidth'(go.chars) << ShiftWidth'({off_o, 3'b000}));
  end

  // A new numeral loads when nothing is shown or the last character is shown now.
  assign take = !active || (count == itr_pkg::CountWidth'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (take) begin
      active <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (in_valid) begin
        chars <= line_next;
        empty <= (total == '0);
        count <= (total == '0) ? itr_pkg::CountWidth'(1) : total;
      end
    end else begin
      chars <= chars >> itr_pkg::SymbolWidth;
      count <= count - itr_pkg::CountWidth'(1);
    end
  end

  assign strobe   = active;
  assign symbol   = chars[itr_pkg::SymbolWidth-1:0];
  assign is_empty = empty;
  assign is_last  = (count == itr_pkg::CountWidth'(1));

endmodule

@@ rtl/integer_to_roman_core.sv @@
// Top level of the integer to Roman numeral converter.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         start high, busy low      number
//   result   out        strobe high, one cycle    symbol, is_empty, is_last
//
// A number transferred at a clock edge is split into digits over four register
// stages, and the emitter then loads it and puts its first character on the result ports.
// The emitter sends one character per cycle, so a number whose numeral has k
// characters (1 to 16, an empty numeral counting as one) holds the output for all k
// of them; that emitter sets the sustained rate, and short numerals follow every cycle.
// Reset is synchronous and clears all valid flags; no data is kept across it.
// The receiver cannot stall; busy rises only while the emitter is still sending a
// longer numeral and the last digit stage holds a number waiting behind it.
module integer_to_roman_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [itr_pkg::NumberWidth-1:0] number,
  output logic                            strobe,
  output logic [itr_pkg::SymbolWidth-1:0] symbol,
  output logic                            is_empty,
  output logic                            is_last
);

  logic             split_valid;
  itr_pkg::digits_t split_digits;
  logic             take;
  logic             advance;

  // The digit pipeline moves when its last stage is empty or the emitter takes it.
  assign advance = !split_valid || take;
  assign busy    = !advance;

  itr_split u_split (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (start),
    .number    (number),
    .out_valid (split_valid),
    .digits    (split_digits)
  );

  itr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (split_valid),
    .digits   (split_digits),
    .take     (take),
    .strobe   (strobe),
    .symbol   (symbol),
    .is_empty (is_empty),
    .is_last  (is_last)
  );

`ifndef SYNTH
  // An empty numeral is a single transfer on its own.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && is_empty |-> is_last)
    else $error("empty numeral not marked last");

  // The characters of one numeral leave without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last |=> strobe)
    else $error("gap inside a numeral");

  // The empty marker carries a zero symbol.
  a_empty_symbol: assert property (@(posedge clk) disable iff (rst)
    strobe && is_empty |-> symbol == '0)
    else $error("empty numeral with a nonzero symbol");

  // Backpressure only comes from an emitter that is busy sending.
  a_busy_emitting: assert property (@(posedge clk) disable iff (rst)
    busy |-> strobe && !is_last)
    else $error("busy without a numeral in progress");
`endif

endmodule

@@ tb/sv/tb_integer_to_roman_core.sv @@
// Self-checking testbench for the integer to Roman numeral converter core.
`timescale 1ns / 1ps

module tb_integer_to_roman_core;

  // ASCII codes of the numeral symbols, kept apart from the package so that a
  // wrong code in the design cannot hide behind the same wrong code here.
  localparam logic [itr_pkg::SymbolWidth-1:0] SymM = 8'h4D;
  localparam logic [itr_pkg::SymbolWidth-1:0] SymD = 8'h44;
  localparam logic [itr_pkg::SymbolWidth-1:0] SymC = 8'h43;
  localparam logic [itr_pkg::SymbolWidth-1:0] SymL = 8'h4C;
  localparam logic [itr_pkg::SymbolWidth-1:0] SymX = 8'h58;
  localparam logic [itr_pkg::SymbolWidth-1:0] SymV = 8'h56;
  localparam logic [itr_pkg::SymbolWidth-1:0] SymI = 8'h49;

  localparam int unsigned MaxNumber   = (1 << itr_pkg::NumberWidth) - 1;
  localparam int unsigned RandomItems = 460;
  // The tail wait covers the trip through the digit stages and also a full
  // sixteen-character numeral still draining.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReported = 10;

  // One character of a numeral as it appears on the result ports.
  typedef struct {
    logic [itr_pkg::SymbolWidth-1:0] symbol;
    logic                            is_empty;
    logic                            is_last;
  } roman_char_t;

  // One number waiting to be sent, with the idle cycles that follow its transfer.
  typedef struct {
    logic [itr_pkg::NumberWidth-1:0] value;
    int unsigned                     idle_after;
  } number_item_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic [itr_pkg::NumberWidth-1:0] number = '0;
  logic                            busy;
  logic                            strobe;
  logic [itr_pkg::SymbolWidth-1:0] symbol;
  logic                            is_empty;
  logic                            is_last;

  number_item_t                    pending_numbers[$];
  roman_char_t                     expected_chars[$];
  logic [itr_pkg::SymbolWidth-1:0] numeral_text[$];
  int unsigned                     idle_left = 0;
  int unsigned                     mismatch_count = 0;

  integer_to_roman_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .number   (number),
    .strobe   (strobe),
    .symbol   (symbol),
    .is_empty (is_empty),
    .is_last  (is_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Appends the symbols of one decimal digit to the numeral being built.
  function automatic void append_digit(input int unsigned digit,
                                       input logic [itr_pkg::SymbolWidth-1:0] one,
                                       input logic [itr_pkg::SymbolWidth-1:0] five,
                                       input logic [itr_pkg::SymbolWidth-1:0] ten);
    int unsigned k;
    if (digit >= 1 && digit <= 3) begin
      for (k = 0; k < digit; k++) numeral_text.push_back(one);
    end else if (digit == 4) begin
      numeral_text.push_back(one);
      numeral_text.push_back(five);
    end else if (digit >= 5 && digit <= 8) begin
      numeral_text.push_back(five);
      for (k = 5; k < digit; k++) numeral_text.push_back(one);
    end else if (digit == 9) begin
      numeral_text.push_back(one);
      numeral_text.push_back(ten);
    end
  endfunction

  // Works out the characters of the numeral for one transferred number and
  // queues them in the order the core must send them.
  function automatic void predict_numeral(input logic [itr_pkg::NumberWidth-1:0] value);
    int unsigned n;
    int unsigned thou;
    int unsigned k;
    roman_char_t ch;
    n    = value;
    thou = n / 1000;
    numeral_text.delete();
    // Only a thousands digit from one to four gives 'M's; larger ones give nothing.
    if (thou >= 1 && thou <= 4) begin
      for (k = 0; k < thou; k++) numeral_text.push_back(SymM);
    end
    append_digit((n % 1000) / 100, SymC, SymD, SymM);
    append_digit((n % 100) / 10, SymX, SymL, SymC);
    append_digit(n % 10, SymI, SymV, SymX);
    if (numeral_text.size() == 0) begin
      // An empty numeral is still reported, as one flagged character.
      ch.symbol   = '0;
      ch.is_empty = 1'b1;
      ch.is_last  = 1'b1;
      expected_chars.push_back(ch);
    end else begin
      for (k = 0; k < numeral_text.size(); k++) begin
        ch.symbol   = numeral_text[k];
        ch.is_empty = 1'b0;
        ch.is_last  = (k + 1 == numeral_text.size());
        expected_chars.push_back(ch);
      end
    end
  endfunction

  // Idle cycles after a transfer: mostly none or short, now and then long.
  // Dense stretches send back to back so that busy gets exercised hard.
  function automatic int unsigned pick_idle(input bit dense);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (dense) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random numbers spread over the interesting regions of the 14-bit field.
  function automatic logic [itr_pkg::NumberWidth-1:0] pick_number();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return itr_pkg::NumberWidth'($urandom_range(1, 4999));
    if (roll < 60) return itr_pkg::NumberWidth'($urandom_range(0, 99));
    if (roll < 70) return itr_pkg::NumberWidth'($urandom_range(0, 4) * 1000 + 888);
    if (roll < 80) return itr_pkg::NumberWidth'($urandom_range(5000, MaxNumber));
    // Round values: many of these have empty numerals or short ones.
    if (roll < 90) return itr_pkg::NumberWidth'($urandom_range(0, 16) * 1000 +
                                       $urandom_range(0, 1) * 100 * $urandom_range(0, 9));
    return itr_pkg::NumberWidth'($urandom);
  endfunction

  // Driver. It tracks the input transfer on the same edge that the core sees it,
  // predicts the numeral right away, and then either holds the item while the
  // core is busy, idles, or presents the next pending number.
  always @(posedge clk) begin
    number_item_t item;
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) predict_numeral(number);
      if (start && busy) begin
        // The transfer has not happened yet, so start and number stay put.
      end else if (idle_left > 0) begin
        start     <= 1'b0;
        number    <= itr_pkg::NumberWidth'($urandom);
        idle_left <= idle_left - 1;
      end else if (pending_numbers.size() > 0) begin
        item = pending_numbers.pop_front();
        start     <= 1'b1;
        number    <= item.value;
        idle_left <= item.idle_after;
      end else begin
        start  <= 1'b0;
        number <= itr_pkg::NumberWidth'($urandom);
      end
    end
  end

  // Monitor. Each strobed character is taken at the edge that ends its cycle
  // and compared field by field with the oldest predicted character.
  always @(posedge clk) begin
    roman_char_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        if (mismatch_count < MaxReported)
          $display("ERROR: unexpected character symbol=%h is_empty=%b is_last=%b",
                   symbol, is_empty, is_last);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = expected_chars.pop_front();
        if (symbol !== want.symbol || is_empty !== want.is_empty ||
            is_last !== want.is_last) begin
          if (mismatch_count < MaxReported)
            $display({"ERROR: character mismatch, expected symbol=%h is_empty=%b ",
                      "is_last=%b, got symbol=%h is_empty=%b is_last=%b"},
                     want.symbol, want.is_empty, want.is_last,
                     symbol, is_empty, is_last);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    number_item_t item;
    logic [itr_pkg::NumberWidth-1:0] directed[$];
    bit dense;
    int i;

    // Directed part: zero, every ones digit including both subtractive forms,
    // the longest numeral, the edges of the 'M' range, thousands digits above
    // four with and without lower digits, and the top of the field.
    directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 40, 90, 400, 900, 1994, 3999,
                 4000, 4888, 4999, 5000, 5001, 9999, 10000, 15888, MaxNumber};
    foreach (directed[j]) begin
      item.value      = directed[j];
      item.idle_after = pick_idle(1'b0);
      pending_numbers.push_back(item);
    end

    // Random part, alternating between dense and mixed stretches.
    dense = 1'b0;
    for (i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) dense = ($urandom_range(0, 2) == 0);
      item.value      = pick_number();
      item.idle_after = pick_idle(dense);
      pending_numbers.push_back(item);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_numbers.size() != 0 || start || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("integer_to_roman_core test passed");
    end else begin
      $display("integer_to_roman_core test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("integer_to_roman_core test failed");
    $finish;
  end

endmodule
